### design/hbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and fixed constants of the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE      = 2'd0,
      CMD_SAMPLE     = 2'd1,
      CMD_PERCENTILE = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PX, ST_PY, ST_QX, ST_QY, ST_FRAC,
      ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RDW,
      ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
      ST_FIN,
      ST_P_EST, ST_P_INIT, ST_P_SCAN, ST_P_DRAIN, ST_P_DECIDE
   } state_type;

   localparam logic [2:0] CSR_X_EXP        = 3'd0;
   localparam logic [2:0] CSR_Y_EXP        = 3'd1;
   localparam logic [2:0] CSR_MAP_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_MAP_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_X_STEP       = 3'd4;
   localparam logic [2:0] CSR_Y_STEP       = 3'd5;
   localparam logic [2:0] CSR_PERCENT_MODE = 3'd6;

   localparam int CSR_DATA_W = 17;
   localparam int MUL_A_W    = 29;
   localparam int MUL_B_W    = 26;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int PX_W       = 27;
   localparam int PY_W       = 26;
   localparam int R_W        = 38;
   localparam int ACC_W      = 64;
   localparam int LO_SPLIT   = 25;

   localparam logic [9:0]  STEP_SCALE  = 10'd1000;
   localparam logic [7:0]  HEIGHT_MAX  = 8'd255;
   localparam logic [6:0]  PCT_MAX     = 7'd100;
   localparam logic [27:0] SUM_SAT     = 28'd256000000;

   // floor(n / 125) = (n * RECIP_125) >> 31 for n < 2**24
   localparam logic [24:0] RECIP_125   = 25'd17179870;
   // floor(n / 15625) = (n * RECIP_15625) >> 36 for n < 2**22
   localparam logic [22:0] RECIP_15625 = 23'd4398047;
   // floor(n / 100) = (n * RECIP_100) >> 21 for n < 2**15
   localparam logic [14:0] RECIP_100   = 15'd20972;

endpackage

### design/heightmap_bilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Byte heightmap grid with bilinear sampling and percentile threshold search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on rsp_value for one cycle with rsp_valid, in the cycle after the work
// ends, and must be taken then. Writes, unknown commands and samples outside
// the map never raise busy, so they run one per cycle. A sample holds busy
// while one shared 29x26 multiplier walks through the coordinate products,
// the divisions by 1000 and, after four grid reads, the bilinear sum.
// A percentile query holds busy through estimate and setup states, then up to
// 9 bisection steps, each a scan of the fx * fy used cells by the single grid
// read port, one cell per cycle, then a drain and a decide. Grid cells read
// before being written give undefined heights; there is no clearing pass.
module heightmap_bilinear_sampler
   import hbs_pkg::*;
#(
   parameter int MAX_X_EXP = 7,
   parameter int MAX_Y_EXP = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [9:0]            req_coord_x,
   input  logic [9:0]            req_coord_y,
   input  logic [7:0]            req_cell_value,
   input  logic signed [7:0]     req_percent,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_value,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int GRID_COLS  = (1 << MAX_X_EXP) + 1;
   localparam int GRID_ROWS  = (1 << MAX_Y_EXP) + 1;
   localparam int GRID_DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW         = $clog2(GRID_DEPTH);
   localparam int XW         = MAX_X_EXP + 1;
   localparam int YW         = MAX_Y_EXP + 1;
   localparam int CW         = MAX_X_EXP + MAX_Y_EXP + 1;
   localparam int SW         = CW + 7;
   localparam logic [AW-1:0] ROWS_A = AW'(GRID_ROWS);

   // configuration
   logic [2:0]  x_exp_ff, y_exp_ff;
   logic [9:0]  map_width_ff, map_height_ff;
   logic [16:0] x_step_ff;
   logic [15:0] y_step_ff;
   logic        percent_mode_ff;

   state_type state_ff, state_in;

   logic [9:0]  cx_ff, cy_ff;
   logic [6:0]  pc_ff;
   logic [PX_W-1:0] px_ff, ex_ff;
   logic [PY_W-1:0] py_ff, ey_ff;
   logic [XW-1:0] lx_ff, sx_ff, rd_x;
   logic [YW-1:0] ly_ff, sy_ff, rd_y;
   logic [7:0]  g00_ff, g10_ff, g01_ff, g11_ff;
   logic signed [R_W-1:0]   r0_ff, r1_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [MUL_P_W-1:0] mul_ff;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [7:0]  est_ff, lo_ff, hi_ff;
   logic [CW-1:0] below_ff;
   logic        scan_vld_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_value_ff;

   logic [7:0]  grid_mem [GRID_DEPTH];
   logic [7:0]  rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;

   logic        accept, in_map, in_grid;
   logic [3:0]  xe_sat, ye_sat;
   logic [XW-1:0] fxm1, lxc;
   logic [YW-1:0] fym1, lyc;
   logic [23:0] q_div;
   logic [27:0] ex_full, ey_full;
   logic signed [MUL_A_W-1:0] op_a, op_b, op_c, op_d;
   logic signed [MUL_B_W-1:0] lo0, hi0, lo1, hi1;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [6:0]  pc_in;
   logic [14:0] pc_x255;
   logic [7:0]  est_init;
   logic        scan_last;
   logic [4:0]  shamt;
   logic [SW-1:0] scaled;
   logic        go_up;
   logic [7:0]  nhi, nlo, nest;
   logic [8:0]  hl_sum;
   logic [7:0]  h_raw, h_out;
   logic [14:0] h_pct;
   logic        fin_en;
   logic [7:0]  fin_value;

   assign accept  = start && !busy;
   assign in_map  = (req_coord_x < map_width_ff) && (req_coord_y < map_height_ff);
   assign in_grid = (req_coord_x < 10'(GRID_COLS)) && (req_coord_y < 10'(GRID_ROWS));

   assign xe_sat = (x_exp_ff == 3'd0) ? 4'd1 :
                   ({1'b0, x_exp_ff} > 4'(MAX_X_EXP)) ? 4'(MAX_X_EXP) : {1'b0, x_exp_ff};
   assign ye_sat = (y_exp_ff == 3'd0) ? 4'd1 :
                   ({1'b0, y_exp_ff} > 4'(MAX_Y_EXP)) ? 4'(MAX_Y_EXP) : {1'b0, y_exp_ff};
   assign fxm1 = (XW'(1) << xe_sat) - XW'(1);
   assign fym1 = (YW'(1) << ye_sat) - YW'(1);

   // integer part of a step product, clamped to the last used cell
   assign q_div   = mul_ff[54:31];
   assign lxc     = (q_div > 24'(fxm1)) ? fxm1 : q_div[XW-1:0];
   assign lyc     = (q_div > 24'(fym1)) ? fym1 : q_div[YW-1:0];
   assign ex_full = 28'(px_ff) - 28'(lxc) * 28'(STEP_SCALE);
   assign ey_full = 28'(py_ff) - 28'(lyc) * 28'(STEP_SCALE);

   assign op_b = $signed({2'b0, ex_ff});
   assign op_a = $signed(29'(STEP_SCALE)) - op_b;
   assign op_d = $signed({3'b0, ey_ff});
   assign op_c = $signed(29'(STEP_SCALE)) - op_d;
   assign lo0  = $signed({1'b0, r0_ff[LO_SPLIT-1:0]});
   assign hi0  = $signed({{13{r0_ff[R_W-1]}}, r0_ff[R_W-1:LO_SPLIT]});
   assign lo1  = $signed({1'b0, r1_ff[LO_SPLIT-1:0]});
   assign hi1  = $signed({{13{r1_ff[R_W-1]}}, r1_ff[R_W-1:LO_SPLIT]});
   assign prod_ext = $signed({{9{mul_ff[MUL_P_W-1]}}, mul_ff});

   // final height
   assign h_raw = (acc_ff[ACC_W-1] || acc_ff == '0) ? 8'd0 :
                  (acc_ff >= $signed(64'(SUM_SAT))) ? HEIGHT_MAX : mul_ff[43:36];
   assign h_pct = 15'(h_raw) * 15'(PCT_MAX);
   assign h_out = percent_mode_ff ? {1'b0, h_pct[14:8]} : h_raw;

   // percentile bisection
   assign pc_in    = req_percent[7] ? 7'd0 :
                     (req_percent[6:0] > PCT_MAX) ? PCT_MAX : req_percent[6:0];
   assign pc_x255  = 15'(pc_ff) * 15'(HEIGHT_MAX);
   assign est_init = mul_ff[28:21];
   assign scan_last = (sx_ff == fxm1) && (sy_ff == fym1);
   assign shamt    = 5'(xe_sat) + 5'(ye_sat);
   assign scaled   = (SW'(below_ff) * SW'(PCT_MAX)) >> shamt;
   assign go_up    = scaled > SW'(pc_ff);
   assign nhi      = go_up ? est_ff : hi_ff;
   assign nlo      = go_up ? lo_ff : est_ff;
   assign hl_sum   = 9'(nhi) + 9'(nlo);
   assign nest     = hl_sum[8:1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_SAMPLE && in_map) begin
               state_in = ST_PX;
            end else if (accept && req_command == CMD_PERCENTILE) begin
               state_in = ST_P_EST;
            end
         end
         ST_PX:    state_in = ST_PY;
         ST_PY:    state_in = ST_QX;
         ST_QX:    state_in = ST_QY;
         ST_QY:    state_in = ST_FRAC;
         ST_FRAC:  state_in = ST_RD0;
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_RD2;
         ST_RD2:   state_in = ST_RD3;
         ST_RD3:   state_in = ST_RDW;
         ST_RDW:   state_in = ST_M0;
         ST_M0:    state_in = ST_M1;
         ST_M1:    state_in = ST_M2;
         ST_M2:    state_in = ST_M3;
         ST_M3:    state_in = ST_M4;
         ST_M4:    state_in = ST_M5;
         ST_M5:    state_in = ST_M6;
         ST_M6:    state_in = ST_M7;
         ST_M7:    state_in = ST_M8;
         ST_M8:    state_in = ST_M9;
         ST_M9:    state_in = ST_FIN;
         ST_FIN:   state_in = ST_IDLE;
         ST_P_EST: state_in = ST_P_INIT;
         ST_P_INIT: state_in = (est_init == 8'd0) ? ST_IDLE : ST_P_SCAN;
         ST_P_SCAN: begin
            if (scan_last) begin
               state_in = ST_P_DRAIN;
            end
         end
         ST_P_DRAIN:  state_in = ST_P_DECIDE;
         ST_P_DECIDE: state_in = (nest == nlo) ? ST_IDLE : ST_P_SCAN;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      rd_x      = lx_ff;
      rd_y      = ly_ff;
      fin_en    = 1'b0;
      fin_value = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            fin_en = accept && !(req_command == CMD_SAMPLE && in_map)
                     && (req_command != CMD_PERCENTILE);
         end
         ST_PX: begin
            mul_a = $signed(29'(x_step_ff));
            mul_b = $signed(26'(cx_ff));
         end
         ST_PY: begin
            mul_a = $signed(29'(y_step_ff));
            mul_b = $signed(26'(cy_ff));
         end
         ST_QX: begin
            mul_a = $signed(29'(px_ff[PX_W-1:3]));
            mul_b = $signed(26'(RECIP_125));
         end
         ST_QY: begin
            mul_a = $signed(29'(py_ff[PY_W-1:3]));
            mul_b = $signed(26'(RECIP_125));
         end
         ST_RD1: rd_x = lx_ff + XW'(1);
         ST_RD2: rd_y = ly_ff + YW'(1);
         ST_RD3: begin
            rd_x = lx_ff + XW'(1);
            rd_y = ly_ff + YW'(1);
         end
         ST_M0: begin
            mul_a = op_a;
            mul_b = $signed(26'(g00_ff));
         end
         ST_M1: begin
            mul_a = op_b;
            mul_b = $signed(26'(g10_ff));
         end
         ST_M2: begin
            mul_a = op_a;
            mul_b = $signed(26'(g01_ff));
         end
         ST_M3: begin
            mul_a = op_b;
            mul_b = $signed(26'(g11_ff));
         end
         ST_M4: begin
            mul_a = op_c;
            mul_b = lo0;
         end
         ST_M5: begin
            mul_a = op_c;
            mul_b = hi0;
         end
         ST_M6: begin
            mul_a = op_d;
            mul_b = lo1;
         end
         ST_M7: begin
            mul_a = op_d;
            mul_b = hi1;
         end
         ST_M9: begin
            mul_a = $signed(29'(acc_ff[27:6]));
            mul_b = $signed(26'(RECIP_15625));
         end
         ST_FIN: begin
            fin_en    = 1'b1;
            fin_value = h_out;
         end
         ST_P_EST: begin
            mul_a = $signed(29'(pc_x255));
            mul_b = $signed(26'(RECIP_100));
         end
         ST_P_INIT: fin_en = (est_init == 8'd0);
         ST_P_SCAN: begin
            rd_x = sx_ff;
            rd_y = sy_ff;
         end
         ST_P_DECIDE: begin
            fin_en    = (nest == nlo);
            fin_value = nest;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = AW'(rd_x) * ROWS_A + AW'(rd_y);
   assign wr_addr = AW'(req_coord_x[XW-1:0]) * ROWS_A + AW'(req_coord_y[YW-1:0]);
   assign wr_en   = accept && (req_command == CMD_WRITE) && in_grid;

   // grid memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= req_cell_value;
      end
      rd_ff <= grid_mem[rd_addr];
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         scan_vld_ff     <= 1'b0;
         x_exp_ff        <= 3'd7;
         y_exp_ff        <= 3'd6;
         map_width_ff    <= 10'd1;
         map_height_ff   <= 10'd1;
         x_step_ff       <= 17'd1000;
         y_step_ff       <= 16'd1000;
         percent_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin_en;
         scan_vld_ff  <= (state_ff == ST_P_SCAN);
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_X_EXP:        x_exp_ff        <= csr_write_data[2:0];
               CSR_Y_EXP:        y_exp_ff        <= csr_write_data[2:0];
               CSR_MAP_WIDTH:    map_width_ff    <= csr_write_data[9:0];
               CSR_MAP_HEIGHT:   map_height_ff   <= csr_write_data[9:0];
               CSR_X_STEP:       x_step_ff       <= csr_write_data[16:0];
               CSR_Y_STEP:       y_step_ff       <= csr_write_data[15:0];
               CSR_PERCENT_MODE: percent_mode_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_ff       <= mul_a * mul_b;
      rsp_value_ff <= fin_value;
      if (scan_vld_ff && (rd_ff < est_ff)) begin
         below_ff <= below_ff + CW'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_ff <= req_coord_x;
               cy_ff <= req_coord_y;
               pc_ff <= pc_in;
            end
         end
         ST_PY: px_ff <= mul_ff[PX_W-1:0];
         ST_QX: py_ff <= mul_ff[PY_W-1:0];
         ST_QY: begin
            lx_ff <= lxc;
            ex_ff <= ex_full[PX_W-1:0];
         end
         ST_FRAC: begin
            ly_ff <= lyc;
            ey_ff <= ey_full[PY_W-1:0];
         end
         ST_RD1: g00_ff <= rd_ff;
         ST_RD2: g10_ff <= rd_ff;
         ST_RD3: g01_ff <= rd_ff;
         ST_RDW: g11_ff <= rd_ff;
         ST_M1:  r0_ff <= mul_ff[R_W-1:0];
         ST_M2:  r0_ff <= r0_ff + mul_ff[R_W-1:0];
         ST_M3:  r1_ff <= mul_ff[R_W-1:0];
         ST_M4:  r1_ff <= r1_ff + mul_ff[R_W-1:0];
         ST_M5:  acc_ff <= prod_ext;
         ST_M6:  acc_ff <= acc_ff + (prod_ext <<< LO_SPLIT);
         ST_M7:  acc_ff <= acc_ff + prod_ext;
         ST_M8:  acc_ff <= acc_ff + (prod_ext <<< LO_SPLIT);
         ST_P_INIT: begin
            est_ff   <= est_init;
            lo_ff    <= 8'd0;
            hi_ff    <= HEIGHT_MAX;
            sx_ff    <= '0;
            sy_ff    <= '0;
            below_ff <= '0;
         end
         ST_P_SCAN: begin
            if (sy_ff == fym1) begin
               sy_ff <= '0;
               sx_ff <= sx_ff + XW'(1);
            end else begin
               sy_ff <= sy_ff + YW'(1);
            end
         end
         ST_P_DECIDE: begin
            hi_ff    <= nhi;
            lo_ff    <= nlo;
            est_ff   <= nest;
            sx_ff    <= '0;
            sy_ff    <= '0;
            below_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heightmap bilinear sampler. Grid cells are
// written on demand ahead of any request that reads them, then directed
// requests cover the field extremes, every command and the corner cases.
// Random phases follow, each with its own register setting. A behavioral
// predictor keeps its own copy of the grid and registers and checks each
// response in order.
// ----------------------------------------------------------------------------
module testbench;
   import hbs_pkg::*;

   localparam int GRID_COLS    = 129;
   localparam int GRID_ROWS    = 65;
   localparam int STALL_LIMIT  = 20000;

   typedef struct {
      cmd_type           cmd;
      logic [9:0]        x;
      logic [9:0]        y;
      logic [7:0]        val;
      logic signed [7:0] pct;
   } hmap_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_command = '0;
   logic [9:0]            req_coord_x = '0;
   logic [9:0]            req_coord_y = '0;
   logic [7:0]            req_cell_value = '0;
   logic signed [7:0]     req_percent = '0;
   logic                  rsp_valid;
   logic [7:0]            rsp_value;
   logic                  csr_write_en = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   heightmap_bilinear_sampler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_cell_value(req_cell_value),
      .req_percent(req_percent), .rsp_valid(rsp_valid), .rsp_value(rsp_value),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  height_mem [GRID_COLS][GRID_ROWS];
   bit          cell_set [GRID_COLS][GRID_ROWS];
   logic [2:0]  m_x_exp = 3'd7, m_y_exp = 3'd6;
   logic [9:0]  m_map_w = 10'd1, m_map_h = 10'd1;
   logic [16:0] m_x_step = 17'd1000;
   logic [15:0] m_y_step = 16'd1000;
   logic        m_pct_mode = 1'b0;

   hmap_req_type pending_reqs[$];
   logic [7:0]   expected_heights[$];
   hmap_req_type cur_req;
   int           errors = 0;
   int           burst_left = 4, gap_left = 0, stall_cycles = 0;

   function automatic int used_cols();
      int e = (m_x_exp < 1) ? 1 : (m_x_exp > 7) ? 7 : m_x_exp;
      return 1 << e;
   endfunction

   function automatic int used_rows();
      int e = (m_y_exp < 1) ? 1 : (m_y_exp > 6) ? 6 : m_y_exp;
      return 1 << e;
   endfunction

   function automatic logic [7:0] bilinear_height(logic [9:0] cx, logic [9:0] cy);
      longint px, py, lx, ly, ex, ey, acc;
      int h;
      if (cx >= m_map_w || cy >= m_map_h) return 8'd0;
      px = longint'(m_x_step) * cx;
      py = longint'(m_y_step) * cy;
      lx = px / 1000;
      if (lx > used_cols() - 1) lx = used_cols() - 1;
      ly = py / 1000;
      if (ly > used_rows() - 1) ly = used_rows() - 1;
      ex = px - lx * 1000;
      ey = py - ly * 1000;
      acc = (1000 - ex) * (1000 - ey) * longint'(height_mem[lx][ly])
          + ex * (1000 - ey) * longint'(height_mem[lx + 1][ly])
          + (1000 - ex) * ey * longint'(height_mem[lx][ly + 1])
          + ex * ey * longint'(height_mem[lx + 1][ly + 1]);
      acc = acc / 1000000;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      h = int'(acc);
      if (m_pct_mode) h = (h * 100) >> 8;
      return h[7:0];
   endfunction

   function automatic logic [7:0] percentile_height(logic signed [7:0] pct);
      int p = pct;
      int lo = 0, hi = 255, est, below;
      int fx = used_cols(), fy = used_rows();
      if (p < 0) p = 0;
      if (p > 100) p = 100;
      est = 255 * p / 100;
      while (est != lo) begin
         below = 0;
         for (int x = 0; x < fx; x++)
            for (int y = 0; y < fy; y++)
               if (height_mem[x][y] < est) below++;
         if ((100 * below) / (fx * fy) > p) hi = est;
         else lo = est;
         est = (hi + lo) / 2;
      end
      return est[7:0];
   endfunction

   function automatic logic [7:0] predict_response(hmap_req_type r);
      case (r.cmd)
         CMD_WRITE: begin
            if (r.x < GRID_COLS && r.y < GRID_ROWS) height_mem[r.x][r.y] = r.val;
            return 8'd0;
         end
         CMD_SAMPLE:     return bilinear_height(r.x, r.y);
         CMD_PERCENTILE: return percentile_height(r.pct);
         default:        return 8'd0;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) expected_heights = {expected_heights, predict_response(cur_req)};
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_command    <= cur_req.cmd;
            req_coord_x    <= cur_req.x;
            req_coord_y    <= cur_req.y;
            req_cell_value <= cur_req.val;
            req_percent    <= cur_req.pct;
            start <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_heights.size() == 0) begin
            $display("%0t: unexpected response value %0d", $time, rsp_value);
            errors++;
         end else begin
            logic [7:0] want;
            want = expected_heights.pop_front();
            if (rsp_value !== want) begin
               $display("%0t: value mismatch expected %0d actual %0d", $time, want,
                        rsp_value);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_req(hmap_req_type r);
      pending_reqs = {pending_reqs, r};
      if (r.cmd == CMD_WRITE && r.x < GRID_COLS && r.y < GRID_ROWS)
         cell_set[r.x][r.y] = 1'b1;
   endtask

   // write a cell ahead of a request that reads it
   task automatic fill_cell(int x, int y);
      hmap_req_type w;
      if (!cell_set[x][y]) begin
         w.cmd = CMD_WRITE; w.x = 10'(x); w.y = 10'(y);
         w.val = 8'($urandom); w.pct = '0;
         queue_req(w);
      end
   endtask

   task automatic add_req(cmd_type c, int x, int y, int v, int p);
      hmap_req_type r;
      longint px, py, lx, ly;
      r.cmd = c; r.x = 10'(x); r.y = 10'(y); r.val = 8'(v); r.pct = 8'(p);
      if (c == CMD_SAMPLE && r.x < m_map_w && r.y < m_map_h) begin
         px = longint'(m_x_step) * r.x;
         py = longint'(m_y_step) * r.y;
         lx = px / 1000;
         if (lx > used_cols() - 1) lx = used_cols() - 1;
         ly = py / 1000;
         if (ly > used_rows() - 1) ly = used_rows() - 1;
         fill_cell(int'(lx), int'(ly));
         fill_cell(int'(lx) + 1, int'(ly));
         fill_cell(int'(lx), int'(ly) + 1);
         fill_cell(int'(lx) + 1, int'(ly) + 1);
      end else if (c == CMD_PERCENTILE) begin
         for (int i = 0; i < used_cols(); i++)
            for (int j = 0; j < used_rows(); j++)
               fill_cell(i, j);
      end
      queue_req(r);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_X_EXP:        m_x_exp = data[2:0];
         CSR_Y_EXP:        m_y_exp = data[2:0];
         CSR_MAP_WIDTH:    m_map_w = data[9:0];
         CSR_MAP_HEIGHT:   m_map_h = data[9:0];
         CSR_X_STEP:       m_x_step = data[16:0];
         CSR_Y_STEP:       m_y_step = data[15:0];
         CSR_PERCENT_MODE: m_pct_mode = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_heights.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_regs(int xe, int ye, int mw, int mh, int xs, int ys, int pm);
      write_reg(CSR_X_EXP, CSR_DATA_W'(xe));
      write_reg(CSR_Y_EXP, CSR_DATA_W'(ye));
      write_reg(CSR_MAP_WIDTH, CSR_DATA_W'(mw));
      write_reg(CSR_MAP_HEIGHT, CSR_DATA_W'(mh));
      write_reg(CSR_X_STEP, CSR_DATA_W'(xs));
      write_reg(CSR_Y_STEP, CSR_DATA_W'(ys));
      write_reg(CSR_PERCENT_MODE, CSR_DATA_W'(pm));
   endtask

   task automatic random_phase(int count);
      int cells = used_cols() * used_rows();
      int pct_weight = (cells <= 256) ? 10 : 0;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            if ($urandom_range(0, 9) == 0)
               add_req(CMD_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom, $urandom);
            else
               add_req(CMD_WRITE, $urandom_range(0, used_cols()),
                       $urandom_range(0, used_rows()), $urandom, $urandom);
         end else if (r < 30 + pct_weight) begin
            add_req(CMD_PERCENTILE, $urandom, $urandom, $urandom, $urandom);
         end else if (r < 95) begin
            if ($urandom_range(0, 7) == 0)
               add_req(CMD_SAMPLE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom, $urandom);
            else
               add_req(CMD_SAMPLE, $urandom_range(0, m_map_w > 0 ? m_map_w - 1 : 0),
                       $urandom_range(0, m_map_h > 0 ? m_map_h - 1 : 0),
                       $urandom, $urandom);
         end else begin
            add_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
         end
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      add_req(CMD_SAMPLE, 0, 0, 0, 0);
      add_req(CMD_SAMPLE, 1, 0, 0, 0);
      add_req(CMD_SAMPLE, 0, 1, 0, 0);
      drain();

      // tiny grid, extreme steps, writes off the grid, odd commands
      set_regs(1, 1, 1023, 1023, 128000, 64000, 1);
      add_req(CMD_WRITE, 0, 0, 255, 0);
      add_req(CMD_WRITE, 1, 1, 0, 0);
      add_req(CMD_WRITE, 2, 2, 255, 0);
      add_req(CMD_WRITE, 1023, 0, 17, 0);
      add_req(CMD_WRITE, 0, 1023, 17, 0);
      add_req(CMD_WRITE, 129, 65, 17, 0);
      add_req(CMD_SAMPLE, 0, 0, 0, 0);
      add_req(CMD_SAMPLE, 1, 1, 0, 0);
      add_req(CMD_SAMPLE, 1022, 1022, 0, 0);
      add_req(CMD_SAMPLE, 1023, 0, 0, 0);
      add_req(CMD_NONE, 1023, 1023, 255, -1);
      add_req(CMD_PERCENTILE, 0, 0, 0, 0);
      add_req(CMD_PERCENTILE, 0, 0, 0, 100);
      add_req(CMD_PERCENTILE, 0, 0, 0, 101);
      add_req(CMD_PERCENTILE, 0, 0, 0, -1);
      add_req(CMD_PERCENTILE, 0, 0, 0, 50);
      add_req(CMD_PERCENTILE, 0, 0, 0, -128);
      add_req(CMD_PERCENTILE, 1023, 1023, 255, 127);
      drain();
      set_regs(0, 7, 3, 3, 0, 65535, 0);
      add_req(CMD_SAMPLE, 2, 2, 0, 0);
      add_req(CMD_SAMPLE, 2, 3, 0, 0);
      add_req(CMD_PERCENTILE, 0, 0, 0, 25);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         set_regs($urandom_range(0, 7), $urandom_range(0, 7),
                  ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 60),
                  ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 60),
                  $urandom_range(0, 131071), $urandom_range(0, 65535),
                  $urandom_range(0, 1));
         random_phase(110);
      end
      set_regs(7, 6, 1023, 1023, 128000, 64000, 1);
      random_phase(110);
      set_regs(1, 1, 1, 1, 0, 0, 0);
      random_phase(80);

      repeat (50) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
